>>> sv/onewire_master_slot_timer_assert.svh
// ----------------------------------------------------------------------------
// onewire_master_slot_timer_assert.svh
// Assertion macros for the one-wire slot timer, clocked by i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_MASTER_SLOT_TIMER_ASSERT_SVH
`define ONEWIRE_MASTER_SLOT_TIMER_ASSERT_SVH

// Check that a condition implies another in the same cycle
`define OWMST_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("owmst check failed in the same cycle");

// Check that a condition implies another in the next cycle
`define OWMST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("owmst check failed in the next cycle");

`endif

>>> sv/owmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owmst_pkg
// Shared types and codes of the one-wire bus master slot timer.
// ----------------------------------------------------------------------------
package owmst_pkg;

    // Configuration register file
    localparam int CFG_W     = 10;
    localparam int IDX_W     = 4;
    localparam int NUM_REGS  = 8;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_RESET_LOW     = 4'd0;
    localparam logic [IDX_W-1:0] REG_PRESENCE_SMP  = 4'd1;
    localparam logic [IDX_W-1:0] REG_RESET_TAIL    = 4'd2;
    localparam logic [IDX_W-1:0] REG_SHORT_LOW     = 4'd3;
    localparam logic [IDX_W-1:0] REG_READ_SMP      = 4'd4;
    localparam logic [IDX_W-1:0] REG_READ_TAIL     = 4'd5;
    localparam logic [IDX_W-1:0] REG_WRITE0_LOW    = 4'd6;
    localparam logic [IDX_W-1:0] REG_WRITE_SLOT    = 4'd7;

    // Reset values of the registers, in ticks
    localparam logic [CFG_W-1:0] RST_RESET_LOW    = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_SMP = 10'd70;
    localparam logic [CFG_W-1:0] RST_RESET_TAIL   = 10'd410;
    localparam logic [CFG_W-1:0] RST_SHORT_LOW    = 10'd6;
    localparam logic [CFG_W-1:0] RST_READ_SMP     = 10'd6;
    localparam logic [CFG_W-1:0] RST_READ_TAIL    = 10'd55;
    localparam logic [CFG_W-1:0] RST_WRITE0_LOW   = 10'd60;
    localparam logic [CFG_W-1:0] RST_WRITE_SLOT   = 10'd70;

    // Command codes on the mode field
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_RESET = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;
    localparam logic [1:0] MODE_WRITE = 2'd3;

    // One tick request
    typedef struct packed {
        logic [1:0] mode;
        logic       write_value;
        logic       line_level;
    } t_item;

    // One tick result
    typedef struct packed {
        logic drive_low;
        logic busy_res;
        logic done_res;
        logic read_value;
        logic reset_failed;
    } t_result;

endpackage

>>> sv/owmst_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owmst_cfg
// Duration register file. Values are stored already clamped to the
// counter range: zero becomes one tick, large values saturate.
// ----------------------------------------------------------------------------
module owmst_cfg #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  logic [owmst_pkg::IDX_W-1:0]     i_index,
    input  logic [owmst_pkg::CFG_W-1:0]     i_data,
    output logic [COUNT_WIDTH-1:0]          o_dur [owmst_pkg::NUM_REGS]
);

    localparam int WIDE_W = 17;
    localparam logic [WIDE_W-1:0] MAX_CNT = WIDE_W'((1 << COUNT_WIDTH) - 1);

    logic [COUNT_WIDTH-1:0] r_dur [owmst_pkg::NUM_REGS];
    logic [COUNT_WIDTH-1:0] n_val;

    // Clamp a written duration to [1, counter max]
    function automatic logic [COUNT_WIDTH-1:0] clamp(input logic [owmst_pkg::CFG_W-1:0] v);
        logic [WIDE_W-1:0] w;
        w = WIDE_W'(v);
        if (w == '0) begin
            w = WIDE_W'(1);
        end
        if (w > MAX_CNT) begin
            w = MAX_CNT;
        end
        return w[COUNT_WIDTH-1:0];
    endfunction

    assign n_val = clamp(i_data);

    // Hold durations, load on a write request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur[0] <= clamp(owmst_pkg::RST_RESET_LOW);
            r_dur[1] <= clamp(owmst_pkg::RST_PRESENCE_SMP);
            r_dur[2] <= clamp(owmst_pkg::RST_RESET_TAIL);
            r_dur[3] <= clamp(owmst_pkg::RST_SHORT_LOW);
            r_dur[4] <= clamp(owmst_pkg::RST_READ_SMP);
            r_dur[5] <= clamp(owmst_pkg::RST_READ_TAIL);
            r_dur[6] <= clamp(owmst_pkg::RST_WRITE0_LOW);
            r_dur[7] <= clamp(owmst_pkg::RST_WRITE_SLOT);
        end else if (i_wr) begin
            unique case (i_index)
                owmst_pkg::REG_RESET_LOW:    r_dur[0] <= n_val;
                owmst_pkg::REG_PRESENCE_SMP: r_dur[1] <= n_val;
                owmst_pkg::REG_RESET_TAIL:   r_dur[2] <= n_val;
                owmst_pkg::REG_SHORT_LOW:    r_dur[3] <= n_val;
                owmst_pkg::REG_READ_SMP:     r_dur[4] <= n_val;
                owmst_pkg::REG_READ_TAIL:    r_dur[5] <= n_val;
                owmst_pkg::REG_WRITE0_LOW:   r_dur[6] <= n_val;
                owmst_pkg::REG_WRITE_SLOT:   r_dur[7] <= n_val;
                default: ;
            endcase
        end
    end

    assign o_dur = r_dur;

endmodule

>>> sv/owmst_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owmst_core
// Slot sequencer: phase, tick counter and sample stores. Computes one tick
// result from the registered request and advances the state on i_en.
// ----------------------------------------------------------------------------
module owmst_core #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  owmst_pkg::t_item            i_item,
    input  logic [COUNT_WIDTH-1:0]      i_dur [owmst_pkg::NUM_REGS],
    output owmst_pkg::t_result          o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LOW,
        PH_WAIT,
        PH_TAIL
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_count, n_count;
    logic [1:0]             r_kind,  n_kind;
    logic                   r_bit,   n_bit;
    logic                   r_pres,  n_pres;
    logic                   r_rdbit, n_rdbit;
    logic                   r_fail,  n_fail;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [COUNT_WIDTH-1:0] len;
    logic                   wr_bit;
    logic [COUNT_WIDTH-1:0] wr_low;
    logic [COUNT_WIDTH-1:0] wr_rec;
    logic                   drive;
    logic                   busy;
    logic                   done;

    // Bit of the write slot: the new command's bit on a start, else the held one
    assign wr_bit = (r_phase == PH_IDLE && i_item.mode != owmst_pkg::MODE_TICK) ?
                    i_item.write_value : r_bit;

    // Write recovery: slot minus low time, at least one tick
    assign wr_low = wr_bit ? i_dur[3] : i_dur[6];
    assign wr_rec = (i_dur[7] > wr_low) ? (i_dur[7] - wr_low) : COUNT_WIDTH'(1);

    // Start a command when idle, then step the current phase
    always_comb begin
        n_phase = r_phase;
        n_count = r_count;
        n_kind  = r_kind;
        n_bit   = r_bit;
        n_pres  = r_pres;
        n_rdbit = r_rdbit;
        n_fail  = r_fail;
        drive   = 1'b0;
        busy    = 1'b0;
        done    = 1'b0;
        len     = i_dur[0];
        cnt_inc = '0;

        if (r_phase == PH_IDLE && i_item.mode != owmst_pkg::MODE_TICK) begin
            n_kind  = i_item.mode;
            n_bit   = i_item.write_value;
            n_phase = PH_LOW;
            n_count = '0;
        end

        if (n_phase != PH_IDLE) begin
            busy    = 1'b1;
            cnt_inc = n_count + COUNT_WIDTH'(1);
            n_count = cnt_inc;
            unique case (n_phase)
                PH_LOW: begin
                    drive = 1'b1;
                    if (n_kind == owmst_pkg::MODE_RESET) begin
                        len = i_dur[0];
                    end else if (n_kind == owmst_pkg::MODE_READ) begin
                        len = i_dur[3];
                    end else begin
                        len = wr_low;
                    end
                    if (cnt_inc >= len) begin
                        n_phase = (n_kind == owmst_pkg::MODE_WRITE) ? PH_TAIL : PH_WAIT;
                        n_count = '0;
                    end
                end
                PH_WAIT: begin
                    len = (n_kind == owmst_pkg::MODE_RESET) ? i_dur[1] : i_dur[4];
                    if (cnt_inc >= len) begin
                        if (n_kind == owmst_pkg::MODE_RESET) begin
                            n_pres = i_item.line_level;
                        end else begin
                            n_rdbit = i_item.line_level;
                        end
                        n_phase = PH_TAIL;
                        n_count = '0;
                    end
                end
                default: begin
                    if (n_kind == owmst_pkg::MODE_RESET) begin
                        len = i_dur[2];
                    end else if (n_kind == owmst_pkg::MODE_READ) begin
                        len = i_dur[5];
                    end else begin
                        len = wr_rec;
                    end
                    if (cnt_inc >= len) begin
                        if (n_kind == owmst_pkg::MODE_RESET) begin
                            n_fail = n_pres | ~i_item.line_level;
                        end
                        done    = 1'b1;
                        n_phase = PH_IDLE;
                        n_count = '0;
                    end
                end
            endcase
        end
    end

    // Advance state on an accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_count <= '0;
            r_kind  <= '0;
            r_bit   <= 1'b0;
            r_pres  <= 1'b0;
            r_rdbit <= 1'b0;
            r_fail  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_kind  <= n_kind;
            r_bit   <= n_bit;
            r_pres  <= n_pres;
            r_rdbit <= n_rdbit;
            r_fail  <= n_fail;
        end
    end

    assign o_res.drive_low    = drive;
    assign o_res.busy_res     = busy;
    assign o_res.done_res     = done;
    assign o_res.read_value   = n_rdbit;
    assign o_res.reset_failed = n_fail;

endmodule

>>> sv/onewire_master_slot_timer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// onewire_master_slot_timer
// One-wire bus master slot timer: reset pulse, read slot and write slot
// sequencing, one request per microsecond tick.
// ----------------------------------------------------------------------------
// Usage:
//   Send one request per bus tick on the input channel (mode, write_value,
//   line_level). A nonzero mode starts a reset, read or write while idle;
//   commands given during an operation are ignored. Each request gives one
//   result: drive_low for the open-drain pin, busy, a done pulse on the last
//   tick, the last read bit and the last reset-failure flag.
//   A result passes through the input register, then the result register,
//   before it is offered. Throughput: one request per cycle while the
//   receiver keeps ready high; the sequencer step is a single compare
//   against the selected duration between those two registers.
//   Stall: when the receiver holds ready low, the result register holds;
//   in_ready drops in the same cycle once the input register is full, and
//   an empty input register still takes one request first.
//   Durations are to be written on the config channel while idle (the block
//   itself does not enforce this); ready is always high there and indexes
//   beyond the register list are dropped. Reset: the sequencer goes idle,
//   stores clear and durations return to their default tick counts.
// ----------------------------------------------------------------------------
module onewire_master_slot_timer #(
    parameter int COUNT_WIDTH = 10
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // request channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [1:0]                      i_mode,
    input  logic                            i_write_value,
    input  logic                            i_line_level,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_drive_low,
    output logic                            o_busy_res,
    output logic                            o_done_res,
    output logic                            o_read_value,
    output logic                            o_reset_failed,
    // configuration channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [owmst_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [owmst_pkg::CFG_W-1:0]     i_cfg_data
);

    logic                   r_in_valid;
    owmst_pkg::t_item       r_in;
    logic                   r_out_valid;
    owmst_pkg::t_result     r_out;
    owmst_pkg::t_result     step_res;
    logic                   adv;
    logic [COUNT_WIDTH-1:0] dur [owmst_pkg::NUM_REGS];

    // Step when a request is held and the result slot frees up
    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;
    assign o_cfg_ready = 1'b1;

    owmst_cfg #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_dur   (dur)
    );

    owmst_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_in),
        .i_dur   (dur),
        .o_res   (step_res)
    );

    // Capture a request into the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in.mode        <= i_mode;
            r_in.write_value <= i_write_value;
            r_in.line_level  <= i_line_level;
        end
    end

    // Load the result register, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= step_res;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_drive_low    = r_out.drive_low;
    assign o_busy_res     = r_out.busy_res;
    assign o_done_res     = r_out.done_res;
    assign o_read_value   = r_out.read_value;
    assign o_reset_failed = r_out.reset_failed;

    // Checks
    `include "onewire_master_slot_timer_assert.svh"

    `OWMST_ASSERT_NEXT(a_adv_fills_out, adv, r_out_valid)
    `OWMST_ASSERT_SAME(a_done_is_busy, r_out_valid && r_out.done_res, r_out.busy_res)
    `OWMST_ASSERT_SAME(a_done_released, r_out_valid && r_out.done_res, !r_out.drive_low)
    `OWMST_ASSERT_SAME(a_drive_is_busy, r_out_valid && r_out.drive_low, r_out.busy_res)

endmodule
